@@ design/planar_velocity_to_steer_drive_unit_macros.svh @@
// Assertion macros used by the checker file of the steer drive unit.
`ifndef PLANAR_VELOCITY_TO_STEER_DRIVE_UNIT_MACROS_SVH
`define PLANAR_VELOCITY_TO_STEER_DRIVE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PVSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("steer drive assertion failed");

// next-cycle implication, disabled in reset
`define PVSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("steer drive assertion failed");

`endif

@@ design/pvsd_pkg.sv @@
// Constants, widths, tables and types of the steer drive unit.
package pvsd_pkg;

  localparam int FRAC_BITS     = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_TAB_LEN  = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;
  localparam int GUARD_BITS    = 8;

  localparam int VEL_W   = 16;
  localparam int SPD_W   = 17;
  localparam int ANG_W   = 9;
  localparam int DUTY_W  = 14;
  localparam int GAIN_W  = 10;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam int CW      = 28;
  localparam int ZW      = 32;
  localparam int UXW     = CW - 2;
  localparam int INV_W   = 32;
  localparam int PW      = UXW + INV_W;
  localparam int MAG_W   = 16;
  localparam int AZW     = ZW - 1;
  localparam int SCALE_W = 14;
  localparam int APW     = AZW + SCALE_W;
  localparam int Q_SHIFT = 30;
  localparam int QW      = APW - Q_SHIFT;
  localparam int RECIP_W = 13;
  localparam int QPW     = QW + RECIP_W;
  localparam int RECIP_SHIFT = 19;
  localparam int AW      = QPW - RECIP_SHIFT;
  localparam int DPW     = MAG_W + GAIN_W;

  localparam logic [INV_W-1:0]   INV_GAIN_Q32 = 32'd2608131496;
  localparam logic [SCALE_W-1:0] ANGLE_SCALE  = 14'd15916;
  localparam logic [RECIP_W-1:0] RECIP_100    = 13'd5243;
  localparam int SPEED_MAX = 46341;
  localparam int ANGLE_MAX = 250;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = 10'd100;
  localparam logic [DUTY_W-1:0] LIMIT_RESET = 14'd16383;

  localparam logic REG_DUTY_GAIN  = 1'b0;
  localparam logic REG_DUTY_LIMIT = 1'b1;

  localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_TAB_LEN] = '{
    32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
    32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
    32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
    32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
    32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
    32'sd1023,      32'sd511,       32'sd255,       32'sd127
  };

  typedef struct packed {
    logic             xneg;
    logic             xzero;
    logic             yzero;
    logic             yneg;
    logic [VEL_W-1:0] ymag;
  } pvsd_side_t;

endpackage

@@ design/pvsd_cordic.sv @@
// Pipelined vectoring CORDIC, one rotation per register stage.
module pvsd_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [pvsd_pkg::CW-1:0] in_cx,
  input  logic signed [pvsd_pkg::CW-1:0] in_cy,
  input  pvsd_pkg::pvsd_side_t          in_side,
  output logic                          out_valid,
  output logic signed [pvsd_pkg::CW-1:0] out_cx,
  output logic signed [pvsd_pkg::ZW-1:0] out_z,
  output pvsd_pkg::pvsd_side_t          out_side
);
  import pvsd_pkg::*;

  logic              vld_r    [NUM_STAGES];
  logic              vld_nxt  [NUM_STAGES];
  logic signed [CW-1:0] cx_r  [NUM_STAGES];
  logic signed [CW-1:0] cx_nxt[NUM_STAGES];
  logic signed [CW-1:0] cy_r  [NUM_STAGES];
  logic signed [CW-1:0] cy_nxt[NUM_STAGES];
  logic signed [ZW-1:0] z_r   [NUM_STAGES];
  logic signed [ZW-1:0] z_nxt [NUM_STAGES];
  pvsd_side_t        side_r   [NUM_STAGES];
  pvsd_side_t        side_nxt [NUM_STAGES];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    logic              src_v;
    logic signed [CW-1:0] src_cx;
    logic signed [CW-1:0] src_cy;
    logic signed [ZW-1:0] src_z;
    pvsd_side_t        src_side;

    if (g == 0) begin : g_head
      assign src_v    = in_valid;
      assign src_cx   = in_cx;
      assign src_cy   = in_cy;
      assign src_z    = '0;
      assign src_side = in_side;
    end else begin : g_body
      assign src_v    = vld_r[g-1];
      assign src_cx   = cx_r[g-1];
      assign src_cy   = cy_r[g-1];
      assign src_z    = z_r[g-1];
      assign src_side = side_r[g-1];
    end

    assign vld_nxt[g]  = src_v;
    assign side_nxt[g] = src_side;
    assign cx_nxt[g] = src_cy[CW-1] ? (src_cx - (src_cy >>> g)) : (src_cx + (src_cy >>> g));
    assign cy_nxt[g] = src_cy[CW-1] ? (src_cy + (src_cx >>> g)) : (src_cy - (src_cx >>> g));
    assign z_nxt[g]  = src_cy[CW-1] ? (src_z - ATAN_Q30[g]) : (src_z + ATAN_Q30[g]);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        cx_r[i]   <= cx_nxt[i];
        cy_r[i]   <= cy_nxt[i];
        z_r[i]    <= z_nxt[i];
        side_r[i] <= side_nxt[i];
      end
    end
  end

  assign out_valid = vld_r[NUM_STAGES-1];
  assign out_cx    = cx_r[NUM_STAGES-1];
  assign out_z     = z_r[NUM_STAGES-1];
  assign out_side  = side_r[NUM_STAGES-1];

endmodule

@@ design/planar_velocity_to_steer_drive_unit.sv @@
// Top level: velocity command to wheel speed, steering code and PWM duty pair.
// Pipeline: 21 register stages from the accepting edge to the result in the output register
// (1 setup, 16 CORDIC, 3 scaling, 1 output).
// Throughput: one item per cycle while not stalled; every stage is a register, all advance together.
// The whole pipeline holds only while a result waits at the output under stall.
// Synchronous active-low reset clears valid bits and loads duty_gain 100, duty_limit 16383.
module planar_velocity_to_steer_drive_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pvsd_pkg::VEL_W-1:0] in_vel_x,
  input  logic signed [pvsd_pkg::VEL_W-1:0] in_vel_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pvsd_pkg::SPD_W-1:0] out_wheel_speed,
  output logic signed [pvsd_pkg::ANG_W-1:0] out_steer_angle,
  output logic [pvsd_pkg::DUTY_W-1:0]       out_duty_forward,
  output logic [pvsd_pkg::DUTY_W-1:0]       out_duty_reverse,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pvsd_pkg::ADDR_W-1:0]       paddr,
  input  logic [pvsd_pkg::DATA_W-1:0]       pwdata,
  output logic [pvsd_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import pvsd_pkg::*;

  logic en;

  logic [GAIN_W-1:0] duty_gain_r;
  logic [DUTY_W-1:0] duty_limit_r;

  logic              pre_vld_r;
  logic signed [CW-1:0] pre_cx_r, pre_cx_nxt;
  logic signed [CW-1:0] pre_cy_r, pre_cy_nxt;
  pvsd_side_t        pre_side_r, pre_side_nxt;

  logic              cor_vld;
  logic signed [CW-1:0] cor_cx;
  logic signed [ZW-1:0] cor_z;
  pvsd_side_t        cor_side;

  logic              m1_vld_r;
  logic [PW-1:0]     m1_prod_r, m1_prod_nxt;
  logic [APW-1:0]    m1_aprod_r, m1_aprod_nxt;
  logic              m1_zneg_r;
  pvsd_side_t        m1_side_r;
  logic [UXW-1:0]    ux;
  logic [AZW-1:0]    az;

  logic              m2_vld_r;
  logic [MAG_W-1:0]  m2_mag_r, m2_mag_nxt;
  logic [QPW-1:0]    m2_qprod_r, m2_qprod_nxt;
  logic              m2_zneg_r;
  pvsd_side_t        m2_side_r;
  logic [PW-1:0]     mag_sum;
  logic [PW-1:0]     mag_sh;
  logic [QW-1:0]     q;

  logic              m3_vld_r;
  logic [SPD_W-1:0]  m3_speed_r, m3_speed_nxt;
  logic [ANG_W-1:0]  m3_angle_r, m3_angle_nxt;
  logic [DPW-1:0]    m3_dprod_r, m3_dprod_nxt;
  logic [AW-1:0]     angle_mag;
  logic [ANG_W-1:0]  angle_lim;
  logic [MAG_W-1:0]  mag_sel;

  logic              out_valid_r;
  logic [SPD_W-1:0]  out_speed_r;
  logic [ANG_W-1:0]  out_angle_r;
  logic [DUTY_W-1:0] out_fwd_r, out_fwd_nxt;
  logic [DUTY_W-1:0] out_rev_r, out_rev_nxt;
  logic [DPW-1:0]    duty_full;
  logic [DUTY_W-1:0] duty_sat;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_gain_r  <= GAIN_RESET;
      duty_limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_DUTY_GAIN:  duty_gain_r  <= pwdata[GAIN_W-1:0];
        REG_DUTY_LIMIT: duty_limit_r <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DUTY_GAIN:  prdata = DATA_W'(duty_gain_r);
      REG_DUTY_LIMIT: prdata = DATA_W'(duty_limit_r);
      default:        prdata = '0;
    endcase
  end

  // hold everything while the output waits under stall
  assign in_stall = out_valid_r && out_stall;
  assign en       = !in_stall;

  // setup: fold the vector into the right half plane
  always_comb begin
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic [VEL_W:0]       yabs;
    xs = CW'(in_vel_x);
    ys = CW'(in_vel_y);
    yabs = in_vel_y[VEL_W-1] ? ((VEL_W+1)'(0) - (VEL_W+1)'(in_vel_y))
                             : (VEL_W+1)'(in_vel_y);
    pre_side_nxt.xneg  = in_vel_x[VEL_W-1];
    pre_side_nxt.xzero = (in_vel_x == '0);
    pre_side_nxt.yzero = (in_vel_y == '0);
    pre_side_nxt.yneg  = in_vel_y[VEL_W-1];
    pre_side_nxt.ymag  = yabs[VEL_W-1:0];
    pre_cx_nxt = (in_vel_x[VEL_W-1] ? -xs : xs) <<< GUARD_BITS;
    pre_cy_nxt = (in_vel_x[VEL_W-1] ? -ys : ys) <<< GUARD_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (en) begin
      pre_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_cx_r   <= pre_cx_nxt;
      pre_cy_r   <= pre_cy_nxt;
      pre_side_r <= pre_side_nxt;
    end
  end

  pvsd_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pre_vld_r),
    .in_cx     (pre_cx_r),
    .in_cy     (pre_cy_r),
    .in_side   (pre_side_r),
    .out_valid (cor_vld),
    .out_cx    (cor_cx),
    .out_z     (cor_z),
    .out_side  (cor_side)
  );

  // stage 1: gain removal and angle scaling products
  always_comb begin
    ux = (!cor_cx[CW-1] && (cor_cx != '0)) ? cor_cx[UXW-1:0] : '0;
    az = cor_z[ZW-1] ? AZW'(-cor_z) : cor_z[AZW-1:0];
    m1_prod_nxt  = PW'(ux) * PW'(INV_GAIN_Q32);
    m1_aprod_nxt = APW'(az) * APW'(ANGLE_SCALE);
  end

  // stage 2: round and clamp the magnitude, divide the angle by 100
  always_comb begin
    mag_sum = m1_prod_r + (PW'(1) << (31 + GUARD_BITS));
    mag_sh  = mag_sum >> (32 + GUARD_BITS);
    m2_mag_nxt = (mag_sh > PW'(SPEED_MAX)) ? MAG_W'(SPEED_MAX) : mag_sh[MAG_W-1:0];
    q = m1_aprod_r[APW-1:Q_SHIFT];
    m2_qprod_nxt = QPW'(q) * QPW'(RECIP_100);
  end

  // stage 3: special cases, signs and the duty product
  always_comb begin
    angle_mag = m2_qprod_r[QPW-1:RECIP_SHIFT];
    angle_lim = (angle_mag > AW'(ANGLE_MAX)) ? ANG_W'(ANGLE_MAX) : ANG_W'(angle_mag);
    if (m2_side_r.xzero && m2_side_r.yzero) begin
      mag_sel      = '0;
      m3_angle_nxt = '0;
    end else if (m2_side_r.xzero) begin
      mag_sel      = m2_side_r.ymag;
      m3_angle_nxt = m2_side_r.yneg ? (ANG_W'(0) - ANG_W'(ANGLE_MAX)) : ANG_W'(ANGLE_MAX);
    end else begin
      mag_sel      = m2_mag_r;
      m3_angle_nxt = m2_zneg_r ? (ANG_W'(0) - angle_lim) : angle_lim;
    end
    m3_speed_nxt = m2_side_r.xneg ? (SPD_W'(0) - SPD_W'(mag_sel)) : SPD_W'(mag_sel);
    m3_dprod_nxt = DPW'(mag_sel) * DPW'(duty_gain_r);
  end

  // output stage: saturate the duty and steer it to one side
  always_comb begin
    duty_full = m3_dprod_r >> FRAC_BITS;
    duty_sat  = (duty_full > DPW'(duty_limit_r)) ? duty_limit_r : duty_full[DUTY_W-1:0];
    if (m3_speed_r[SPD_W-1]) begin
      out_fwd_nxt = '0;
      out_rev_nxt = duty_sat;
    end else begin
      out_fwd_nxt = duty_sat;
      out_rev_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r    <= 1'b0;
      m2_vld_r    <= 1'b0;
      m3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      m1_vld_r    <= cor_vld;
      m2_vld_r    <= m1_vld_r;
      m3_vld_r    <= m2_vld_r;
      out_valid_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_prod_r   <= m1_prod_nxt;
      m1_aprod_r  <= m1_aprod_nxt;
      m1_zneg_r   <= cor_z[ZW-1];
      m1_side_r   <= cor_side;
      m2_mag_r    <= m2_mag_nxt;
      m2_qprod_r  <= m2_qprod_nxt;
      m2_zneg_r   <= m1_zneg_r;
      m2_side_r   <= m1_side_r;
      m3_speed_r  <= m3_speed_nxt;
      m3_angle_r  <= m3_angle_nxt;
      m3_dprod_r  <= m3_dprod_nxt;
      out_speed_r <= m3_speed_r;
      out_angle_r <= m3_angle_r;
      out_fwd_r   <= out_fwd_nxt;
      out_rev_r   <= out_rev_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_wheel_speed  = out_speed_r;
  assign out_steer_angle  = out_angle_r;
  assign out_duty_forward = out_fwd_r;
  assign out_duty_reverse = out_rev_r;

endmodule

@@ design/pvsd_checker.sv @@
// Port-level checker for the steer drive unit and its bind.
`include "planar_velocity_to_steer_drive_unit_macros.svh"

module pvsd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [pvsd_pkg::SPD_W-1:0] out_wheel_speed,
  input logic signed [pvsd_pkg::ANG_W-1:0] out_steer_angle,
  input logic [pvsd_pkg::DUTY_W-1:0]       out_duty_forward,
  input logic [pvsd_pkg::DUTY_W-1:0]       out_duty_reverse
);
  import pvsd_pkg::*;

  `PVSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_wheel_speed) && $stable(out_steer_angle) &&
    $stable(out_duty_forward) && $stable(out_duty_reverse))
  `PVSD_ASSERT_SAME(a_stall_only_when_full, in_stall, out_valid && out_stall)
  `PVSD_ASSERT_SAME(a_duty_side, out_valid,
    (out_wheel_speed[SPD_W-1] ? out_duty_forward : out_duty_reverse) == '0)
  `PVSD_ASSERT_SAME(a_angle_range, out_valid,
    (out_steer_angle <= 9'sd250) && (out_steer_angle >= -9'sd250))

endmodule

bind planar_velocity_to_steer_drive_unit pvsd_checker u_pvsd_checker (.*);
